### rtl/multi_queue_shared_buffer_top_macros.svh
// assertion macros used by the checker file
`ifndef MULTI_QUEUE_SHARED_BUFFER_TOP_MACROS_SVH
`define MULTI_QUEUE_SHARED_BUFFER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MQSB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqsb assertion failed");

// next-cycle implication, disabled while reset is low
`define MQSB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqsb assertion failed");

`endif

### rtl/mqsb_pkg.sv
// shared types, constants and helper functions for the multi-queue buffer
package mqsb_pkg;

    localparam int QUEUE_SLOTS = 8;
    localparam int STORE_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;

    localparam int QSEL_W    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int NQE_W     = $clog2(QUEUE_SLOTS + 1);
    localparam int DIV_CNT_W = $clog2(CNT_W);

    // fixed field widths
    localparam int QIDX_W     = 3;
    localparam int NQ_W       = 4;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [NQ_W-1:0]   NQ_RESET   = NQ_W'(1);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_NUM_QUEUES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ARRAY_SIZE = CFG_IDX_W'(1);

    typedef enum logic {
        FN_ENQ = 1'b0,
        FN_DEQ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_DIV,
        S_TOT,
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        t_func                   func;
        logic [QIDX_W-1:0]       queue_index;
        logic signed [DATA_WIDTH-1:0] value;
    } t_cmd;

    typedef struct packed {
        t_status                 status;
        logic signed [DATA_WIDTH-1:0] data_out;
        logic                    all_full;
    } t_res;

    typedef struct packed {
        logic cfg_we;
        logic div_init;
        logic div_step;
        logic tot_load;
        logic cmd_load;
        logic exec;
    } t_dp_ctl;

    typedef struct packed {
        logic cfg_hit;
    } t_dp_sts;

    function automatic logic [NQE_W-1:0] eff_queues(input logic [NQ_W-1:0] n);
        if (n == '0) begin
            return NQE_W'(1);
        end else if (int'(n) > QUEUE_SLOTS) begin
            return NQE_W'(QUEUE_SLOTS);
        end else begin
            return NQE_W'(n);
        end
    endfunction

    function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return CNT_W'(1);
        end else if (int'(s) > STORE_DEPTH) begin
            return CNT_W'(STORE_DEPTH);
        end else begin
            return CNT_W'(s);
        end
    endfunction

endpackage

### rtl/mqsb_ram.sv
// generic single-port ram with registered read
module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mqsb_ctrl.sv
// controller state machine: capacity setup, command sequencing, result strobe
module mqsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_cfg_valid,
    input  mqsb_pkg::t_dp_sts i_sts,
    output mqsb_pkg::t_dp_ctl o_ctl,
    output logic              o_busy,
    output logic              o_res_valid,
    output logic              o_cfg_ready
);
    import mqsb_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CNT_W - 1);

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        o_ctl       = '0;
        o_cfg_ready = (r_state == S_IDLE) && !i_start;
        o_busy      = (r_state != S_IDLE);
        o_res_valid = (r_state == S_RESP);
        o_ctl.cfg_we = i_cfg_valid && o_cfg_ready;
        unique case (r_state)
            S_INIT: begin
                o_ctl.div_init = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_TOT;
                end else begin
                    n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                end
            end
            S_TOT: begin
                o_ctl.tot_load = 1'b1;
                n_state        = S_IDLE;
            end
            S_IDLE: begin
                priority if (i_sts.cfg_hit) begin
                    n_state = S_INIT;
                end else if (i_start) begin
                    o_ctl.cmd_load = 1'b1;
                    n_state        = S_EXEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

### rtl/mqsb_dp.sv
// datapath: config registers, serial capacity divider, queue pointers, shared store
module mqsb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mqsb_pkg::t_dp_ctl                   i_ctl,
    output mqsb_pkg::t_dp_sts                   o_sts,
    input  mqsb_pkg::t_cmd                      i_cmd,
    input  logic [mqsb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mqsb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mqsb_pkg::t_res                      o_res
);
    import mqsb_pkg::*;

    localparam int PROD_W = NQE_W + CNT_W;
    localparam int BASE_W = QSEL_W + CNT_W;

    // configuration
    logic [NQ_W-1:0]   r_num_queues;
    logic [SIZE_W-1:0] r_array_size;
    logic              w_cfg_nq, w_cfg_size;

    // capacity divider: r_quo starts as the dividend and ends as the capacity
    logic [NQE_W-1:0]  r_nq;
    logic [NQE_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cap_total;
    logic [NQE_W:0]    w_rem_sh, w_rem_sub;
    logic              w_ge;
    logic [PROD_W-1:0] w_prod;

    // queue state
    logic [ADDR_W-1:0] r_head [QUEUE_SLOTS];
    logic [ADDR_W-1:0] r_tail [QUEUE_SLOTS];
    logic [CNT_W-1:0]  r_fill [QUEUE_SLOTS];
    logic [CNT_W-1:0]  r_total;

    // command and result
    t_cmd              r_cmd;
    t_status           r_status, n_status;
    logic              r_deq_ok;
    logic              r_all_full;

    logic [QSEL_W-1:0] w_qsel;
    logic              w_bad;
    logic [CNT_W-1:0]  w_fill;
    logic [ADDR_W-1:0] w_head, w_tail, w_ptr, w_ptr_wrap;
    logic [CNT_W-1:0]  w_ptr_inc;
    logic [BASE_W-1:0] w_base, w_addr_full;
    logic [ADDR_W-1:0] w_addr;
    logic              w_we, w_ram_we;
    logic [CNT_W-1:0]  n_fill_q, n_total;
    logic [ADDR_W-1:0] n_head_q, n_tail_q;
    logic [DATA_WIDTH-1:0] w_rdata;

    assign w_cfg_nq    = i_ctl.cfg_we && (i_cfg_index == REG_NUM_QUEUES);
    assign w_cfg_size  = i_ctl.cfg_we && (i_cfg_index == REG_ARRAY_SIZE);
    assign o_sts.cfg_hit = w_cfg_nq || w_cfg_size;

    // one restoring-division step per cycle
    assign w_rem_sh  = {r_rem, r_quo[CNT_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_nq};
    assign w_ge      = (w_rem_sh >= {1'b0, r_nq});
    assign w_prod    = PROD_W'(r_nq) * PROD_W'(r_quo);

    // selected queue and its slot address
    assign w_qsel      = QSEL_W'(r_cmd.queue_index);
    assign w_bad       = int'(r_cmd.queue_index) >= int'(r_nq);
    assign w_fill      = r_fill[w_qsel];
    assign w_head      = r_head[w_qsel];
    assign w_tail      = r_tail[w_qsel];
    assign w_ptr       = (r_cmd.func == FN_ENQ) ? w_tail : w_head;
    assign w_base      = BASE_W'(w_qsel) * BASE_W'(r_quo);
    assign w_addr_full = w_base + BASE_W'(w_ptr);
    assign w_addr      = w_addr_full[ADDR_W-1:0];
    assign w_ptr_inc   = CNT_W'(w_ptr) + CNT_W'(1);
    assign w_ptr_wrap  = (w_ptr_inc >= r_quo) ? '0 : w_ptr_inc[ADDR_W-1:0];

    always_comb begin
        n_status = ST_OK;
        w_we     = 1'b0;
        n_fill_q = w_fill;
        n_head_q = w_head;
        n_tail_q = w_tail;
        n_total  = r_total;
        priority if (w_bad) begin
            n_status = ST_BAD_INDEX;
        end else if (r_cmd.func == FN_ENQ) begin
            if (w_fill >= r_quo) begin
                n_status = ST_FULL;
            end else begin
                w_we     = 1'b1;
                n_tail_q = w_ptr_wrap;
                n_fill_q = w_fill + CNT_W'(1);
                n_total  = r_total + CNT_W'(1);
            end
        end else begin
            if (w_fill == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_fill_q = w_fill - CNT_W'(1);
                n_total  = r_total - CNT_W'(1);
                // draining a queue rewinds both pointers
                if (w_fill == CNT_W'(1)) begin
                    n_head_q = '0;
                    n_tail_q = '0;
                end else begin
                    n_head_q = w_ptr_wrap;
                end
            end
        end
    end

    assign w_ram_we = i_ctl.exec && w_we;

    mqsb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_addr),
        .i_wdata (r_cmd.value),
        .o_rdata (w_rdata)
    );

    // control state: config and queue bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_queues <= NQ_RESET;
            r_array_size <= SIZE_RESET;
            r_total      <= '0;
            for (int i = 0; i < QUEUE_SLOTS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (w_cfg_nq) begin
                r_num_queues <= i_cfg_data[NQ_W-1:0];
            end
            if (w_cfg_size) begin
                r_array_size <= i_cfg_data[SIZE_W-1:0];
            end
            if (o_sts.cfg_hit) begin
                r_total <= '0;
                for (int i = 0; i < QUEUE_SLOTS; i++) begin
                    r_head[i] <= '0;
                    r_tail[i] <= '0;
                    r_fill[i] <= '0;
                end
            end else if (i_ctl.exec && (n_status == ST_OK)) begin
                r_fill[w_qsel] <= n_fill_q;
                r_head[w_qsel] <= n_head_q;
                r_tail[w_qsel] <= n_tail_q;
                r_total        <= n_total;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_init) begin
            r_nq  <= eff_queues(r_num_queues);
            r_quo <= eff_size(r_array_size);
            r_rem <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= w_ge ? w_rem_sub[NQE_W-1:0] : w_rem_sh[NQE_W-1:0];
            r_quo <= {r_quo[CNT_W-2:0], w_ge};
        end
        if (i_ctl.tot_load) begin
            r_cap_total <= w_prod[CNT_W-1:0];
        end
        if (i_ctl.cmd_load) begin
            r_cmd <= i_cmd;
        end
        if (i_ctl.exec) begin
            r_status   <= n_status;
            r_deq_ok   <= (n_status == ST_OK) && (r_cmd.func == FN_DEQ);
            r_all_full <= (n_total == r_cap_total);
        end
    end

    assign o_res.status   = r_status;
    assign o_res.data_out = r_deq_ok ? w_rdata : '0;
    assign o_res.all_full = r_all_full;

endmodule

### rtl/multi_queue_shared_buffer_top.sv
// top level of the multi-queue shared buffer: controller plus datapath
// the result strobe follows acceptance of start via the execute and respond states
// a new transaction is taken only once the last has passed accept, execute, respond
// reset and every write to a known register clear all queues and run a serial
//   capacity divider: busy stays high through the load, the 7 steps and the total
// results are shown for one cycle only; the receiver cannot stall them
module multi_queue_shared_buffer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  mqsb_pkg::t_cmd                  i_cmd,
    // result channel
    output logic                            o_res_valid,
    output mqsb_pkg::t_res                  o_res,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mqsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mqsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mqsb_pkg::*;

    // command and status between controller and datapath
    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    // controller: sequences capacity setup after reset or config,
    // then steps each transaction through execute and respond
    mqsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl),
        .o_busy      (busy),
        .o_res_valid (o_res_valid),
        .o_cfg_ready (o_cfg_ready)
    );

    // datapath: config registers, per-queue head/tail/fill, running total,
    // and the shared store split into equal partitions
    mqsb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_cmd       (i_cmd),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res)
    );

endmodule

### rtl/mqsb_checker.sv
// port-level checker for the multi-queue shared buffer and its bind
`include "multi_queue_shared_buffer_top_macros.svh"

module mqsb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_res_valid,
    input mqsb_pkg::t_res o_res
);
    import mqsb_pkg::*;

    // an accepted transaction makes the block busy
    `MQSB_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // the result strobe follows acceptance once the execute state has passed
    `MQSB_ASSERT_IMP(a_accept_result, i_clk, i_rst_n, start && !busy, ##2 o_res_valid)

    // a result is only presented while a transaction is in flight
    `MQSB_ASSERT_IMP(a_result_busy, i_clk, i_rst_n, o_res_valid, busy)

    // failed transactions return zero data
    `MQSB_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_res_valid && (o_res.status != ST_OK), o_res.data_out == '0)

endmodule

bind multi_queue_shared_buffer_top mqsb_checker u_mqsb_checker (.*);

### test/tb_top.sv
// self-checking testbench for the multi-queue shared buffer
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mqsb_pkg::*;

    // run length guard, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 200000;
    // cycles to keep watching the result port after the last reply
    localparam int unsigned DRAIN_CYCLES = 8;

    // register indexes that decode to nothing in the block
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

    typedef enum logic {
        OP_CMD,
        OP_CFG
    } t_op_kind;

    // one entry of the driver backlog: a queue command or a register write
    typedef struct {
        t_op_kind                kind;
        t_cmd                    cmd;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        int unsigned             idle_pct;
    } t_queue_op;

    // clock, reset and block ports
    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    t_cmd                   i_cmd       = '0;
    logic                   o_res_valid;
    t_res                   o_res;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // stimulus backlog and replies still owed by the block
    t_queue_op   pending_ops[$];
    t_res        replies_due[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // shadow copy of the buffer: store, per-queue pointers, totals, registers
    logic [DATA_WIDTH-1:0] shadow_mem [STORE_DEPTH];
    int unsigned           q_head [QUEUE_SLOTS];
    int unsigned           q_tail [QUEUE_SLOTS];
    int unsigned           q_fill [QUEUE_SLOTS];
    int unsigned           q_total = 0;
    logic [NQ_W-1:0]       cfg_nq   = NQ_RESET;
    logic [SIZE_W-1:0]     cfg_size = SIZE_RESET;

    // register view used while building stimulus
    logic [NQ_W-1:0]       gen_nq_raw   = NQ_RESET;
    logic [SIZE_W-1:0]     gen_size_raw = SIZE_RESET;
    int unsigned           phase_idle   = 0;

    // driver and monitor scratch
    logic                  drive_start;
    logic                  drive_cfg;
    t_res                  reply_want;

    multi_queue_shared_buffer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // queue count in use: zero acts as one, anything past the maximum saturates
    function automatic int unsigned queue_count(input logic [NQ_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end else if (int'(raw) > QUEUE_SLOTS) begin
            return QUEUE_SLOTS;
        end
        return int'(raw);
    endfunction

    // entries per partition, floor of clamped size over queue count
    function automatic int unsigned partition_cap(input logic [NQ_W-1:0] nq_raw,
                                                  input logic [SIZE_W-1:0] size_raw);
        int unsigned sz;
        if (size_raw == '0) begin
            sz = 1;
        end else if (int'(size_raw) > STORE_DEPTH) begin
            sz = STORE_DEPTH;
        end else begin
            sz = int'(size_raw);
        end
        return sz / queue_count(nq_raw);
    endfunction

    // reply for one accepted command, advancing the shadow queues
    function automatic t_res compute_queue_reply(input t_cmd c);
        int unsigned nq;
        int unsigned cap;
        int unsigned q;
        int unsigned addr;
        t_res        r;
        nq = queue_count(cfg_nq);
        cap = partition_cap(cfg_nq, cfg_size);
        q = int'(c.queue_index);
        r.status = ST_OK;
        r.data_out = '0;
        if (q >= nq) begin
            r.status = ST_BAD_INDEX;
        end else if (c.func == FN_ENQ) begin
            if (q_fill[q] >= cap) begin
                r.status = ST_FULL;
            end else begin
                addr = q * cap + q_tail[q];
                shadow_mem[addr] = c.value;
                q_tail[q] = (q_tail[q] + 1 >= cap) ? 0 : q_tail[q] + 1;
                q_fill[q]++;
                q_total++;
            end
        end else begin
            if (q_fill[q] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                addr = q * cap + q_head[q];
                r.data_out = shadow_mem[addr];
                q_fill[q]--;
                q_total--;
                // a drained queue restarts at the base of its partition
                if (q_fill[q] == 0) begin
                    q_head[q] = 0;
                    q_tail[q] = 0;
                end else begin
                    q_head[q] = (q_head[q] + 1 >= cap) ? 0 : q_head[q] + 1;
                end
            end
        end
        r.all_full = (q_total == nq * cap);
        return r;
    endfunction

    // register write into the shadow; known registers wipe every queue
    function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_NUM_QUEUES) begin
            cfg_nq = val[NQ_W-1:0];
        end else if (idx == REG_ARRAY_SIZE) begin
            cfg_size = val[SIZE_W-1:0];
        end else begin
            return;
        end
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            q_head[i] = 0;
            q_tail[i] = 0;
            q_fill[i] = 0;
        end
        q_total = 0;
    endfunction

    // data word with the sign extremes showing up often
    function automatic logic [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_cmd(input t_func fn, input int unsigned q,
                            input logic [DATA_WIDTH-1:0] val);
        t_queue_op op;
        op.kind = OP_CMD;
        op.cmd.func = fn;
        op.cmd.queue_index = QIDX_W'(q);
        op.cmd.value = val;
        op.reg_idx = '0;
        op.reg_val = '0;
        op.idle_pct = phase_idle;
        pending_ops.push_back(op);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
        t_queue_op op;
        op.kind = OP_CFG;
        op.cmd = '0;
        op.reg_idx = idx;
        op.reg_val = val;
        op.idle_pct = phase_idle;
        if (idx == REG_NUM_QUEUES) begin
            gen_nq_raw = val[NQ_W-1:0];
        end else if (idx == REG_ARRAY_SIZE) begin
            gen_size_raw = val[SIZE_W-1:0];
        end
        pending_ops.push_back(op);
    endtask

    // pick a register setting, biased toward small partitions
    task automatic random_setting();
        logic [NQ_W-1:0]   nq_raw;
        logic [SIZE_W-1:0] size_raw;
        int unsigned       nq;
        case ($urandom_range(9))
            0: begin
                // saturating values on both registers
                nq_raw = NQ_W'(8 + $urandom_range(7));
                size_raw = SIZE_W'($urandom_range(127, 64));
            end
            1: begin
                // zero queue count, tiny or zero size
                nq_raw = '0;
                size_raw = SIZE_W'($urandom_range(3));
            end
            default: begin
                nq = $urandom_range(1, QUEUE_SLOTS);
                nq_raw = NQ_W'(nq);
                size_raw = SIZE_W'(nq * $urandom_range(0, 6) + $urandom_range(nq - 1));
            end
        endcase
        // upper data bits are ignored for the queue count
        if ($urandom_range(1)) begin
            push_cfg(REG_NUM_QUEUES, {3'($urandom_range(7)), nq_raw});
            push_cfg(REG_ARRAY_SIZE, size_raw);
        end else begin
            push_cfg(REG_ARRAY_SIZE, size_raw);
            push_cfg(REG_NUM_QUEUES, {3'($urandom_range(7)), nq_raw});
        end
        // now and then a write that decodes to nothing
        if ($urandom_range(7) == 0) begin
            push_cfg($urandom_range(1) ? REG_UNUSED_3 : REG_UNUSED_2,
                     CFG_DATA_W'($urandom()));
        end
    endtask

    // bursts that fill and drain queues, with some noise and bad indexes
    task automatic random_ops(input int unsigned n_items);
        int unsigned made;
        int unsigned nq;
        int unsigned cap;
        int unsigned q;
        int unsigned len;
        int unsigned mode;
        t_func       fn;
        nq = queue_count(gen_nq_raw);
        cap = partition_cap(gen_nq_raw, gen_size_raw);
        made = 0;
        while (made < n_items) begin
            q = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(nq - 1);
            mode = $urandom_range(9);
            if (mode == 3) begin
                // fill every partition to reach the all-full flag
                for (int i = 0; i < nq; i++) begin
                    for (int k = 0; k < cap; k++) begin
                        push_cmd(FN_ENQ, i, rand_word());
                    end
                end
                push_cmd(FN_ENQ, q, rand_word());
                made += nq * cap + 1;
            end else begin
                len = (mode < 7) ? cap + 1 + $urandom_range(1) : $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    if (mode < 3) begin
                        fn = FN_ENQ;
                    end else if (mode < 7) begin
                        fn = FN_DEQ;
                    end else begin
                        fn = $urandom_range(1) ? FN_DEQ : FN_ENQ;
                    end
                    push_cmd(fn, q, rand_word());
                end
                made += len;
            end
        end
    endtask

    // driver: one command or one register write in flight at a time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            drive_start = start;
            drive_cfg = i_cfg_valid;
            // command transaction accepted at this edge
            if (start && !busy) begin
                replies_due.push_back(compute_queue_reply(i_cmd));
                pending_ops.delete(0);
                drive_start = 1'b0;
            end
            // register transaction accepted at this edge
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register_write(i_cfg_index, i_cfg_data);
                pending_ops.delete(0);
                drive_cfg = 1'b0;
            end
            // nothing held: offer the next backlog entry
            if (!drive_start && !drive_cfg && pending_ops.size() != 0) begin
                if (pending_ops[0].kind == OP_CFG) begin
                    // registers change only once every reply is back
                    if (replies_due.size() == 0) begin
                        drive_cfg = 1'b1;
                        i_cfg_index <= pending_ops[0].reg_idx;
                        i_cfg_data <= pending_ops[0].reg_val;
                    end
                end else if ($urandom_range(99) >= pending_ops[0].idle_pct) begin
                    drive_start = 1'b1;
                    i_cmd <= pending_ops[0].cmd;
                end
            end
            start <= drive_start;
            i_cfg_valid <= drive_cfg;
        end
    end

    // monitor: every strobed result against the oldest owed reply
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (replies_due.size() == 0) begin
                $error("result with no command waiting: status %0d data %h all_full %0b",
                       o_res.status, o_res.data_out, o_res.all_full);
                error_count++;
            end else begin
                reply_want = replies_due.pop_front();
                if (o_res.status !== reply_want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           reply_want.status, o_res.status);
                    error_count++;
                end
                if (o_res.data_out !== reply_want.data_out) begin
                    $error("data_out mismatch: expected %h, actual %h",
                           reply_want.data_out, o_res.data_out);
                    error_count++;
                end
                if (o_res.all_full !== reply_want.all_full) begin
                    $error("all_full mismatch: expected %0b, actual %0b",
                           reply_want.all_full, o_res.all_full);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        // directed: one queue of 64 under the reset setting, sign extremes
        phase_idle = 0;
        push_cmd(FN_ENQ, 0, 32'h7FFF_FFFF);
        push_cmd(FN_ENQ, 0, 32'h8000_0000);
        push_cmd(FN_ENQ, 0, 32'hFFFF_FFFF);
        push_cmd(FN_ENQ, 0, 32'h0000_0000);
        for (int k = 0; k < 4; k++) begin
            push_cmd(FN_DEQ, 0, 32'h5A5A_5A5A);
        end
        // empty queue, then bad indexes on both operations
        push_cmd(FN_DEQ, 0, 32'h0);
        push_cmd(FN_ENQ, 1, 32'h1234_5678);
        push_cmd(FN_DEQ, 7, 32'h0);
        // two queues of one entry: full queue and all-full flag
        push_cfg(REG_NUM_QUEUES, 7'd2);
        push_cfg(REG_ARRAY_SIZE, 7'd3);
        push_cmd(FN_ENQ, 0, 32'hCAFE_0001);
        push_cmd(FN_ENQ, 0, 32'hCAFE_0002);
        push_cmd(FN_ENQ, 1, 32'hCAFE_0003);
        push_cmd(FN_DEQ, 1, 32'h0);
        push_cmd(FN_DEQ, 1, 32'h0);
        // writes to undecoded indexes leave the queues alone
        push_cfg(REG_UNUSED_2, 7'h7F);
        push_cfg(REG_UNUSED_3, 7'h00);
        push_cmd(FN_DEQ, 0, 32'h0);
        push_cmd(FN_ENQ, 0, 32'hBEEF_0004);
        // a real register write wipes the queue that was just filled
        push_cfg(REG_ARRAY_SIZE, 7'd5);
        push_cmd(FN_DEQ, 0, 32'h0);
        // more queues than entries: zero capacity everywhere
        push_cfg(REG_NUM_QUEUES, 7'h75);
        push_cfg(REG_ARRAY_SIZE, 7'd3);
        push_cmd(FN_ENQ, 4, 32'h0BAD_0005);
        push_cmd(FN_DEQ, 0, 32'h0);
        push_cmd(FN_ENQ, 5, 32'h0BAD_0006);
        // zero register values act as one
        push_cfg(REG_NUM_QUEUES, 7'd0);
        push_cfg(REG_ARRAY_SIZE, 7'd0);
        push_cmd(FN_ENQ, 0, 32'h0000_0007);
        // oversized register values saturate: eight queues of eight
        push_cfg(REG_NUM_QUEUES, 7'h0F);
        push_cfg(REG_ARRAY_SIZE, 7'h7F);
        push_cmd(FN_DEQ, 7, 32'h0);
        push_cmd(FN_ENQ, 7, 32'h7777_7777);

        // random phases: no gaps, heavy gaps, no gaps, light gaps
        for (int ph = 0; ph < 4; ph++) begin
            phase_idle = (ph == 1) ? 65 : (ph == 3) ? 17 : 0;
            for (int b = 0; b < 4; b++) begin
                random_setting();
                random_ops(18);
            end
        end
        // end on the widest setting and on the narrowest
        push_cfg(REG_NUM_QUEUES, 7'd8);
        push_cfg(REG_ARRAY_SIZE, 7'd64);
        random_ops(12);
        push_cfg(REG_NUM_QUEUES, 7'd1);
        push_cfg(REG_ARRAY_SIZE, 7'd1);
        random_ops(6);

        // one reset pulse at the start of the run
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the backlog and the owed replies to clear
        while (pending_ops.size() != 0 || replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        // watch for stray strobes a little longer
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
